@@ rtl/core/etjs_pkg.sv @@
// shared types and codes for the job status controller
package etjs_pkg;

    localparam int unsigned CntW  = 16;
    localparam int unsigned DataW = 32;
    localparam int unsigned AddrW = 3;

    // register indexes
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        PH_DORMANT   = 3'd0,
        PH_EXECUTING = 3'd1,
        PH_ABORTING  = 3'd2,
        PH_ABORTED   = 3'd3,
        PH_DONE      = 3'd4,
        PH_ERROR     = 3'd5,
        PH_RESETTING = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        FC_NONE     = 2'd0,
        FC_EXTERNAL = 2'd1,
        FC_TIMEOUT  = 2'd2
    } t_fault;

    typedef struct packed {
        logic tick;
        logic execute;
        logic external_error;
        logic abort_request;
        logic ready_req;
        logic abort_complete;
        logic reset_request;
        logic reset_complete;
    } t_update;

    typedef struct packed {
        logic   done_res;
        logic   busy_res;
        logic   aborted;
        logic   failed;
        t_fault fault_code;
        logic   active_cycle;
        t_phase phase_now;
    } t_status;

endpackage

@@ rtl/core/etjs_fsm.sv @@
// phase state machine, timers and held status flags
module etjs_fsm
    import etjs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  t_update         i_upd,
    input  logic [CntW-1:0] i_timeout_ticks,
    input  logic [CntW-1:0] i_time_limit_ticks,
    output t_status         o_next
);

    t_phase          r_phase, n_phase;
    logic [CntW-1:0] r_timeout_left, n_timeout_left;
    logic [CntW-1:0] r_period_left, n_period_left;
    logic            r_execute_before;
    logic            r_done, n_done;
    logic            r_busy, n_busy;
    logic            r_aborted, n_aborted;
    logic            r_error, n_error;
    t_fault          r_code, n_code;
    logic            r_active, n_active;
    logic            fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_DORMANT;
            r_timeout_left   <= '0;
            r_period_left    <= '0;
            r_execute_before <= 1'b0;
            r_done           <= 1'b0;
            r_busy           <= 1'b0;
            r_aborted        <= 1'b0;
            r_error          <= 1'b0;
            r_code           <= FC_NONE;
            r_active         <= 1'b0;
        end else if (i_accept) begin
            r_phase          <= n_phase;
            r_timeout_left   <= n_timeout_left;
            r_period_left    <= n_period_left;
            r_execute_before <= i_upd.execute;
            r_done           <= n_done;
            r_busy           <= n_busy;
            r_aborted        <= n_aborted;
            r_error          <= n_error;
            r_code           <= n_code;
            r_active         <= n_active;
        end
    end

    always_comb begin
        n_timeout_left = r_timeout_left;
        n_period_left  = r_period_left;
        // timers advance first, only on a tick while executing
        if (i_upd.tick && (r_phase == PH_EXECUTING)) begin
            if (i_time_limit_ticks != '0) begin
                n_period_left = (r_period_left != '0) ? (r_period_left - 1'b1)
                                                      : i_time_limit_ticks;
            end
            if (r_timeout_left != '0) begin
                n_timeout_left = r_timeout_left - 1'b1;
            end
        end
        fault = i_upd.external_error ||
                ((i_timeout_ticks != '0) && (n_timeout_left == '0));

        n_phase   = r_phase;
        n_done    = r_done;
        n_busy    = r_busy;
        n_aborted = r_aborted;
        n_error   = r_error;
        n_code    = r_code;
        n_active  = r_active;

        unique case (r_phase)
            PH_DORMANT: begin
                n_done    = 1'b0;
                n_busy    = 1'b0;
                n_aborted = 1'b0;
                n_error   = 1'b0;
                n_code    = FC_NONE;
                n_active  = 1'b0;
                if (i_upd.execute && !r_execute_before) begin
                    n_timeout_left = i_timeout_ticks;
                    n_period_left  = i_time_limit_ticks;
                    n_phase        = PH_EXECUTING;
                end
            end
            PH_EXECUTING: begin
                n_busy   = 1'b1;
                n_active = (i_time_limit_ticks == '0) || (n_period_left != '0);
                if (fault) begin
                    n_phase = PH_ERROR;
                end else if (i_upd.abort_request) begin
                    n_phase = PH_ABORTING;
                end else if (i_upd.ready_req) begin
                    n_phase = PH_DONE;
                end
            end
            PH_ABORTING: begin
                n_active = 1'b0;
                if (fault) begin
                    n_phase = PH_ERROR;
                end else if (i_upd.abort_complete) begin
                    n_phase = PH_ABORTED;
                end
            end
            PH_ABORTED: begin
                n_busy    = 1'b0;
                n_aborted = 1'b1;
                if (i_upd.reset_request || !i_upd.execute) begin
                    n_phase = PH_RESETTING;
                end
            end
            PH_DONE: begin
                n_busy   = 1'b0;
                n_done   = 1'b1;
                n_active = 1'b0;
                if (i_upd.reset_request || !i_upd.execute) begin
                    n_phase = PH_RESETTING;
                end
            end
            PH_ERROR: begin
                n_busy   = 1'b0;
                n_active = 1'b0;
                n_error  = 1'b1;
                n_code   = i_upd.external_error ? FC_EXTERNAL : FC_TIMEOUT;
                if (i_upd.reset_request || !i_upd.execute) begin
                    n_phase = PH_RESETTING;
                end
            end
            PH_RESETTING: begin
                n_done    = 1'b0;
                n_aborted = 1'b0;
                n_error   = 1'b0;
                n_code    = FC_NONE;
                n_active  = 1'b0;
                if (i_upd.reset_complete) begin
                    n_phase = PH_DORMANT;
                end
            end
            default: begin
            end
        endcase

        o_next.done_res     = n_done;
        o_next.busy_res     = n_busy;
        o_next.aborted      = n_aborted;
        o_next.failed       = n_error;
        o_next.fault_code   = n_code;
        o_next.active_cycle = n_active;
        o_next.phase_now    = n_phase;
    end

endmodule

@@ rtl/core/edge_triggered_job_status_fsm_unit.sv @@
// top level of the job status controller: register port, state machine, result queue
// a result is registered into the output register when it is free, else into the skid register
// one update item per cycle while o_in_stall is low; the state machine updates in the accept cycle
// a two-entry result queue (output register plus skid register) lets an item be
// taken while the previous result still waits; o_in_stall rises only when both are full
// reset: synchronous active low, clears phase, timers, flags, registers and the queue
module edge_triggered_job_status_fsm_unit
    import etjs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // register port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    // update items
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_tick,
    input  logic             i_execute,
    input  logic             i_external_error,
    input  logic             i_abort_request,
    input  logic             i_ready_req,
    input  logic             i_abort_complete,
    input  logic             i_reset_request,
    input  logic             i_reset_complete,
    // result items
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_done_res,
    output logic             o_busy_res,
    output logic             o_aborted,
    output logic             o_failed,
    output logic [1:0]       o_fault_code,
    output logic             o_active_cycle,
    output logic [2:0]       o_phase_now
);

    logic [CntW-1:0] r_timeout_ticks;
    logic [CntW-1:0] r_time_limit_ticks;
    logic            cfg_wr;
    logic            reg_sel;

    t_update         upd;
    t_status         next_status;
    logic            in_acc;
    logic            out_pop;

    t_status         r_out, r_skid;
    logic            r_out_valid, r_skid_valid;

    // register port: zero wait states, byte lanes not used
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks    <= '0;
            r_time_limit_ticks <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TIMEOUT: r_timeout_ticks    <= pwdata[CntW-1:0];
                REG_LIMIT:   r_time_limit_ticks <= pwdata[CntW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_TIMEOUT: prdata[CntW-1:0] = r_timeout_ticks;
            REG_LIMIT:   prdata[CntW-1:0] = r_time_limit_ticks;
            default: begin
            end
        endcase
    end

    // input side: stall only when the skid register is occupied
    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_pop    = r_out_valid && !i_out_stall;

    assign upd.tick           = i_tick;
    assign upd.execute        = i_execute;
    assign upd.external_error = i_external_error;
    assign upd.abort_request  = i_abort_request;
    assign upd.ready_req      = i_ready_req;
    assign upd.abort_complete = i_abort_complete;
    assign upd.reset_request  = i_reset_request;
    assign upd.reset_complete = i_reset_complete;

    // state advances on every accepted item; next_status is the result
    etjs_fsm u_fsm (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_acc),
        .i_upd              (upd),
        .i_timeout_ticks    (r_timeout_ticks),
        .i_time_limit_ticks (r_time_limit_ticks),
        .o_next             (next_status)
    );

    // result queue: output register in front, skid register behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_pop) begin
            // output register frees up: refill from skid first to keep order
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= in_acc;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            // output held by a stalled receiver: park the new result
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (in_acc) begin
                    r_skid <= next_status;
                end
            end else if (in_acc) begin
                r_out <= next_status;
            end
        end else if (in_acc) begin
            r_skid <= next_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_done_res     = r_out.done_res;
    assign o_busy_res     = r_out.busy_res;
    assign o_aborted      = r_out.aborted;
    assign o_failed       = r_out.failed;
    assign o_fault_code   = r_out.fault_code;
    assign o_active_cycle = r_out.active_cycle;
    assign o_phase_now    = r_out.phase_now;

endmodule

@@ rtl/core/etjs_checker.sv @@
// port-level checks for the job status controller, bound to the top level
module etjs_checker
    import etjs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_done_res,
    input logic       o_busy_res,
    input logic       o_aborted,
    input logic       o_failed,
    input logic [1:0] o_fault_code,
    input logic       o_active_cycle,
    input logic [2:0] o_phase_now
);

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result queue not empty after reset");

    // input stalls only while a result is pending
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_phase_now)
            && $stable(o_fault_code))
        else $error("stalled result changed");

    // dormant means every status flag is clear
    a_dormant_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_phase_now == PH_DORMANT) |->
            !o_done_res && !o_busy_res && !o_aborted && !o_failed
            && !o_active_cycle && (o_fault_code == FC_NONE))
        else $error("flag set while dormant");

    // a failed job always carries a fault code
    a_failed_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_failed |-> (o_fault_code != FC_NONE))
        else $error("failed without fault code");

endmodule

bind edge_triggered_job_status_fsm_unit etjs_checker u_etjs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_done_res     (o_done_res),
    .o_busy_res     (o_busy_res),
    .o_aborted      (o_aborted),
    .o_failed       (o_failed),
    .o_fault_code   (o_fault_code),
    .o_active_cycle (o_active_cycle),
    .o_phase_now    (o_phase_now)
);
